// ===== rtl/mat3i_pkg.sv =====
// Types, states and index tables shared by the 3x3 inverse core.
package mat3i_pkg;

    localparam int ElemW = 16;
    localparam int CofW  = 34;
    localparam int DetW  = 51;
    localparam int ProdW = 50;
    localparam int InvW  = 32;
    localparam int Npos  = 9;
    localparam int MulOps = 21;

    typedef enum logic [1:0] {
        S_LOAD,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT
    } t_state;

    typedef struct packed {
        logic [3:0] ia;
        logic [3:0] ib;
    } t_pair;

    function automatic logic [1:0] f_row(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] f_col(input logic [3:0] k);
        logic [1:0] c;
        unique case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    // row-major index of the transposed position
    function automatic logic [3:0] f_tidx(input logic [3:0] k);
        logic [1:0] r;
        logic [1:0] c;
        r = f_row(k);
        c = f_col(k);
        return 4'({c, 1'b0} + c + {2'b00, r});
    endfunction

    function automatic logic [3:0] f_at(input logic [1:0] r, input logic [1:0] c);
        return 4'({r, 1'b0} + r + {2'b00, c});
    endfunction

    // operand indices of the two minor products for position k
    function automatic t_pair f_mul_idx(input logic [3:0] k, input logic second);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] r1;
        logic [1:0] r2;
        logic [1:0] c1;
        logic [1:0] c2;
        t_pair p;
        r  = f_row(k);
        c  = f_col(k);
        r1 = (r == 2'd0) ? 2'd1 : 2'd0;
        r2 = (r == 2'd2) ? 2'd1 : 2'd2;
        c1 = (c == 2'd0) ? 2'd1 : 2'd0;
        c2 = (c == 2'd2) ? 2'd1 : 2'd2;
        if (second) begin
            p.ia = f_at(r1, c2);
            p.ib = f_at(r2, c1);
        end else begin
            p.ia = f_at(r1, c1);
            p.ib = f_at(r2, c2);
        end
        return p;
    endfunction

endpackage

// ===== rtl/matrix3_cofactor_inverse_core.sv =====
// 3x3 inverse core: Q8.8 elements in, cofactor, adjugate, determinant and inverse out.
// Nine start beats load a matrix in row-major order; busy stays low while loading.
// The ninth beat raises busy: 21 products go through one shared 16x34 multiplier,
// then each of the nine positions runs a bit-serial divide and emits its result
// beat on o_valid for exactly one cycle, row-major, o_last on the ninth. Start
// beats are ignored while busy. There is no backpressure: the receiver must take
// every beat as it is shown.
module matrix3_cofactor_inverse_core import mat3i_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [ElemW-1:0] i_element,
    output logic                    o_valid,
    output logic [1:0]              o_row,
    output logic [1:0]              o_col,
    output logic signed [ElemW-1:0] o_transposed,
    output logic signed [CofW-1:0]  o_cofactor,
    output logic signed [CofW-1:0]  o_adjugate,
    output logic signed [InvW-1:0]  o_inverse,
    output logic signed [DetW-1:0]  o_determinant,
    output logic                    o_singular,
    output logic                    o_last
);
    t_state r_state;
    t_state n_state;

    logic signed [ElemW-1:0] r_elem [Npos];
    logic signed [CofW-1:0]  r_cof  [Npos];
    logic [3:0]              r_cnt;
    logic [4:0]              r_j;
    logic [4:0]              r_pj;
    logic                    r_pv;
    logic signed [ProdW-1:0] r_prod;
    logic signed [ProdW-1:0] r_acc;
    logic signed [DetW-1:0]  r_det;
    logic [3:0]              r_k;

    logic                    r_valid;
    logic [1:0]              r_row;
    logic [1:0]              r_col;
    logic signed [ElemW-1:0] r_tr;
    logic signed [CofW-1:0]  r_cofo;
    logic signed [CofW-1:0]  r_adj;
    logic signed [InvW-1:0]  r_inv;
    logic                    r_last;

    t_pair                   w_pair;
    logic [3:0]              w_ia;
    logic signed [ElemW-1:0] w_opa;
    logic signed [CofW-1:0]  w_opb;
    logic signed [ProdW-1:0] w_prod;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [InvW-1:0]         w_quot;
    logic                    w_sing;
    logic [3:0]              w_t;
    logic [3:0]              w_dk;

    assign w_sing = (r_det == '0);
    assign w_t    = f_tidx(r_k);
    assign w_pair = f_mul_idx(r_j[4:1], r_j[0]);
    assign w_dk   = 4'(r_j - 5'd18);

    always_comb begin
        if (r_j < 5'd18) begin
            w_ia  = w_pair.ia;
            w_opb = CofW'(r_elem[w_pair.ib]);
        end else begin
            w_ia  = w_dk;
            w_opb = r_cof[w_dk];
        end
        w_opa  = r_elem[w_ia];
        w_prod = ProdW'(w_opa) * ProdW'(w_opb);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:     if (start && r_cnt == 4'd8) n_state = S_MUL;
            S_MUL:      if (r_pv && r_pj == 5'(MulOps - 1)) n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done) n_state = (r_k == 4'd8) ? S_LOAD : S_DIV_GO;
            end
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        busy        = (r_state != S_LOAD);
        w_div_start = (r_state == S_DIV_GO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_j     <= '0;
            r_pv    <= 1'b0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (start) begin
                        r_cnt <= (r_cnt == 4'd8) ? 4'd0 : r_cnt + 4'd1;
                        r_j   <= '0;
                        r_pv  <= 1'b0;
                        r_k   <= '0;
                    end
                end
                S_MUL: begin
                    r_pv <= (r_j < 5'(MulOps));
                    r_pj <= r_j;
                    if (r_j < 5'(MulOps)) r_j <= r_j + 5'd1;
                end
                S_DIV_GO: ;
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_valid <= 1'b1;
                        r_k     <= r_k + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && start) r_elem[r_cnt] <= i_element;
        r_prod <= w_prod;
        if (r_state == S_MUL && r_pv) begin
            if (r_pj < 5'd18) begin
                if (!r_pj[0]) begin
                    r_acc <= r_prod;
                end else if (r_pj[1]) begin
                    r_cof[r_pj[4:1]] <= CofW'(r_prod - r_acc);
                end else begin
                    r_cof[r_pj[4:1]] <= CofW'(r_acc - r_prod);
                end
            end else if (r_pj == 5'd18) begin
                r_det <= DetW'(r_prod);
            end else begin
                r_det <= r_det + DetW'(r_prod);
            end
        end
        if (r_state == S_DIV_WAIT && w_div_done) begin
            r_row  <= f_row(r_k);
            r_col  <= f_col(r_k);
            r_tr   <= r_elem[w_t];
            r_cofo <= r_cof[r_k];
            r_adj  <= r_cof[w_t];
            r_inv  <= w_sing ? '0 : w_quot;
            r_last <= (r_k == 4'd8);
        end
    end

    mat3i_div #(
        .SHIFT (3 * FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_cof[w_t]),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_valid       = r_valid;
    assign o_row         = r_row;
    assign o_col         = r_col;
    assign o_transposed  = r_tr;
    assign o_cofactor    = r_cofo;
    assign o_adjugate    = r_adj;
    assign o_inverse     = r_inv;
    assign o_determinant = r_det;
    assign o_singular    = w_sing;
    assign o_last        = r_last;
endmodule

// ===== rtl/mat3i_div.sv =====
// Bit-serial restoring divider: saturated |num|*2^SHIFT/|den| with sign.
module mat3i_div import mat3i_pkg::*; #(
    parameter int SHIFT = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [CofW-1:0] i_num,
    input  logic signed [DetW-1:0] i_den,
    output logic                   o_done,
    output logic [InvW-1:0]        o_quot
);
    localparam int Steps = CofW + SHIFT;
    localparam int CntW  = $clog2(Steps + 1);

    logic            r_busy;
    logic [CntW-1:0] r_cnt;
    logic [Steps-1:0] r_num;
    logic [DetW-1:0] r_rem;
    logic [DetW-1:0] r_dm;
    logic [InvW:0]   r_q;
    logic            r_sticky;
    logic            r_neg;
    logic            r_done;
    logic [InvW-1:0] r_quot;

    logic [CofW-1:0] w_mag;
    logic [DetW-1:0] w_dm;
    logic [DetW:0]   w_trial;
    logic            w_ge;
    logic [DetW:0]   w_diff;
    logic            w_big_pos;
    logic            w_big_neg;

    assign w_mag     = i_num[CofW-1] ? CofW'(-i_num) : i_num;
    assign w_dm      = i_den[DetW-1] ? DetW'(-i_den) : i_den;
    assign w_trial   = {r_rem, r_num[Steps-1]};
    assign w_ge      = w_trial >= {1'b0, r_dm};
    assign w_diff    = w_trial - {1'b0, r_dm};
    assign w_big_pos = r_sticky | r_q[InvW] | r_q[InvW-1];
    assign w_big_neg = r_sticky | r_q[InvW] | (r_q[InvW-1] & (|r_q[InvW-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= CntW'(Steps);
                r_num    <= Steps'(w_mag) << SHIFT;
                r_rem    <= '0;
                r_dm     <= w_dm;
                r_q      <= '0;
                r_sticky <= 1'b0;
                r_neg    <= i_num[CofW-1] ^ i_den[DetW-1];
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt    <= r_cnt - CntW'(1);
                    r_num    <= r_num << 1;
                    r_rem    <= w_ge ? w_diff[DetW-1:0] : w_trial[DetW-1:0];
                    r_q      <= {r_q[InvW-1:0], w_ge};
                    r_sticky <= r_sticky | r_q[InvW];
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_neg) begin
                        r_quot <= w_big_neg ? 32'h8000_0000 : InvW'(-r_q[InvW-1:0]);
                    end else begin
                        r_quot <= w_big_pos ? 32'h7FFF_FFFF : r_q[InvW-1:0];
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the 3x3 cofactor / adjugate / inverse core.
module tb_top;
    import mat3i_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int SHIFT     = 3 * FRAC_BITS;

    typedef struct {
        logic [1:0]             row;
        logic [1:0]             col;
        logic signed [ElemW-1:0] tr;
        logic signed [CofW-1:0]  cof;
        logic signed [CofW-1:0]  adj;
        logic signed [InvW-1:0]  inv;
        logic signed [DetW-1:0]  det;
        logic                   sing;
        logic                   last;
    } t_result_beat;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [ElemW-1:0] i_element = '0;
    logic                    o_valid;
    logic [1:0]              o_row;
    logic [1:0]              o_col;
    logic signed [ElemW-1:0] o_transposed;
    logic signed [CofW-1:0]  o_cofactor;
    logic signed [CofW-1:0]  o_adjugate;
    logic signed [InvW-1:0]  o_inverse;
    logic signed [DetW-1:0]  o_determinant;
    logic                    o_singular;
    logic                    o_last;

    logic signed [ElemW-1:0] pending_elems[$];
    t_result_beat            expected_beats[$];
    logic signed [ElemW-1:0] elem_store[9];
    int                      load_cnt = 0;
    int                      idle_pct = 0;
    int                      mismatches = 0;
    int                      beats_seen = 0;
    int                      matrices_done = 0;
    int                      singular_seen = 0;

    matrix3_cofactor_inverse_core #(.FRAC_BITS(FRAC_BITS)) DUT (.*);

    always #1 i_clk = ~i_clk;

    // Exact cofactors, determinant and saturated quotient for the stored matrix.
    function automatic void predict_inverse_beats();
        longint cf[3][3];
        longint m;
        longint det;
        longint q;
        int r1, r2, c1, c2;
        t_result_beat b;
        for (int r = 0; r < 3; r++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++) begin
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                m = longint'(elem_store[r1*3+c1]) * longint'(elem_store[r2*3+c2])
                  - longint'(elem_store[r1*3+c2]) * longint'(elem_store[r2*3+c1]);
                cf[r][c] = ((r + c) % 2 == 1) ? -m : m;
            end
        end
        det = longint'(elem_store[0]) * cf[0][0] + longint'(elem_store[1]) * cf[0][1]
            + longint'(elem_store[2]) * cf[0][2];
        for (int k = 0; k < 9; k++) begin
            b.row  = 2'(k / 3);
            b.col  = 2'(k % 3);
            b.tr   = elem_store[(k % 3) * 3 + k / 3];
            b.cof  = CofW'(cf[k / 3][k % 3]);
            b.adj  = CofW'(cf[k % 3][k / 3]);
            b.det  = DetW'(det);
            b.sing = (det == 0);
            b.last = (k == 8);
            if (det == 0) begin
                q = 0;
            end else begin
                q = (cf[k % 3][k / 3] <<< SHIFT) / det;
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
            end
            b.inv = InvW'(q);
            expected_beats.push_back(b);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_element <= '0;
        end else begin
            if (start && !busy) begin
                elem_store[load_cnt] = i_element;
                load_cnt++;
                if (load_cnt == 9) begin
                    load_cnt = 0;
                    predict_inverse_beats();
                end
            end
            if (!(start && busy)) begin
                if (pending_elems.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    start     <= 1'b1;
                    i_element <= pending_elems.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result_beat e;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat row %0d col %0d", o_row, o_col);
            end else begin
                e = expected_beats.pop_front();
                if (e.last) matrices_done++;
                if (e.last && e.sing) singular_seen++;
                if (o_row !== e.row || o_col !== e.col || o_transposed !== e.tr
                    || o_cofactor !== e.cof || o_adjugate !== e.adj
                    || o_inverse !== e.inv || o_determinant !== e.det
                    || o_singular !== e.sing || o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: beat mismatch at row %0d col %0d", e.row, e.col);
                        $display("  exp: r%0d c%0d tr %0d cof %0d adj %0d inv %0d det %0d s%0d l%0d",
                            e.row, e.col, e.tr, e.cof, e.adj, e.inv, e.det, e.sing, e.last);
                        $display("  got: r%0d c%0d tr %0d cof %0d adj %0d inv %0d det %0d s%0d l%0d",
                            o_row, o_col, o_transposed, o_cofactor, o_adjugate, o_inverse,
                            o_determinant, o_singular, o_last);
                    end
                end
            end
        end
    end

    task automatic push_matrix(input int m[9]);
        for (int i = 0; i < 9; i++) pending_elems.push_back(ElemW'(m[i]));
    endtask

    task automatic push_random_matrix();
        int m[9];
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0: m[i] = $urandom_range(8) - 4;
                1: begin
                    case ($urandom_range(3))
                        0: m[i] = -32768;
                        1: m[i] = 32767;
                        2: m[i] = 0;
                        default: m[i] = int'($signed(16'($urandom)));
                    endcase
                end
                2: m[i] = $urandom_range(1024) - 512;
                default: m[i] = int'($signed(16'($urandom)));
            endcase
        end
        // rank-deficient: third row repeats the first
        if ($urandom_range(5) == 0) for (int i = 0; i < 3; i++) m[6+i] = m[i];
        push_matrix(m);
    endtask

    task automatic drain();
        while (pending_elems.size() != 0 || expected_beats.size() != 0 || load_cnt != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int pcts[4] = '{0, 71, 0, 14};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // identity, near-singular with inverse overflow both ways, singular extremes
        push_matrix('{256, 0, 0, 0, 256, 0, 0, 0, 256});
        push_matrix('{32767, 32766, 0, 32766, 32765, 0, 0, 0, 1});
        push_matrix('{32767, -32768, 32767, 32767, -32768, 32767, -32768, 0, 32767});
        drain();
        for (int p = 0; p < 4; p++) begin
            idle_pct = pcts[p];
            for (int n = 0; n < 9; n++) push_random_matrix();
            drain();
        end
        repeat (600) @(posedge i_clk);
        $display("Checked %0d result beats over %0d matrices (%0d singular).",
                 beats_seen, matrices_done, singular_seen);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Mismatch count: %0d", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("ERROR: timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
